### rtl/ors_pkg.sv
package ors_pkg;

    localparam logic [1:0] OP_BEGIN = 2'd0;
    localparam logic [1:0] OP_BIT   = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;
    localparam logic [1:0] OP_ABORT = 2'd3;

    localparam logic [1:0] KIND_DIR     = 2'd0;
    localparam logic [1:0] KIND_FOUND   = 2'd1;
    localparam logic [1:0] KIND_NONE    = 2'd2;
    localparam logic [1:0] KIND_STARTED = 2'd3;

    // Search command the host sends after a pass started result.
    localparam logic [7:0] SEARCH_COMMAND = 8'hF0;
    // Position past the last ROM bit, and the first position past the family byte.
    localparam logic [6:0] FINAL_POSITION = 7'd65;
    localparam logic [6:0] FAMILY_LIMIT   = 7'd9;

    typedef struct packed {
        logic [1:0] operation;
        logic       presence;
        logic       id_bit;
        logic       complement_bit;
    } t_in;

    typedef struct packed {
        logic [1:0]  kind;
        logic        direction;
        logic [63:0] rom_code;
        logic        last_device;
        logic [3:0]  family_discrepancy;
        logic        last;
    } t_out;

    // Results of one item: count (0 to 2) and up to two result words.
    typedef struct packed {
        logic [1:0] cnt;
        t_out       res0;
        t_out       res1;
    } t_core_res;

endpackage

### rtl/ors_core.sv
module ors_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  ors_pkg::t_in      i_item,
    output ors_pkg::t_core_res o_res
);

    logic [63:0] r_rom,    n_rom;
    logic [6:0]  r_ld,     n_ld;
    logic [3:0]  r_fam,    n_fam;
    logic        r_ldev,   n_ldev;
    logic [6:0]  r_pos,    n_pos;
    logic [6:0]  r_lzp,    n_lzp;
    logic        r_active, n_active;

    logic        dir;
    logic [5:0]  idx;
    logic [3:0]  fam_bit;
    logic [1:0]  kind0;
    logic [1:0]  kind1;
    logic [1:0]  cnt;
    logic        done;

    always_comb begin
        n_rom    = r_rom;
        n_ld     = r_ld;
        n_fam    = r_fam;
        n_ldev   = r_ldev;
        n_pos    = r_pos;
        n_lzp    = r_lzp;
        n_active = r_active;
        dir      = 1'b0;
        idx      = 6'(r_pos - 7'd1);
        fam_bit  = r_fam;
        kind0    = ors_pkg::KIND_NONE;
        kind1    = ors_pkg::KIND_NONE;
        cnt      = 2'd0;
        done     = 1'b0;

        case (i_item.operation)
            ors_pkg::OP_BEGIN: begin
                cnt = 2'd1;
                if (r_ldev || !i_item.presence) begin
                    n_ld     = '0;
                    n_fam    = '0;
                    n_ldev   = 1'b0;
                    n_active = 1'b0;
                    kind0    = ors_pkg::KIND_NONE;
                end else begin
                    n_active = 1'b1;
                    n_pos    = 7'd1;
                    n_lzp    = '0;
                    kind0    = ors_pkg::KIND_STARTED;
                end
            end
            ors_pkg::OP_CLEAR: begin
                n_ld     = '0;
                n_fam    = '0;
                n_ldev   = 1'b0;
                n_active = 1'b0;
            end
            ors_pkg::OP_ABORT: begin
                n_active = 1'b0;
                cnt      = 2'd1;
                kind0    = ors_pkg::KIND_NONE;
            end
            ors_pkg::OP_BIT: begin
                if (r_active) begin
                    cnt = 2'd1;
                    if (i_item.id_bit && i_item.complement_bit) begin
                        n_active = 1'b0;
                        n_ld     = '0;
                        n_fam    = '0;
                        n_ldev   = 1'b0;
                        kind0    = ors_pkg::KIND_NONE;
                    end else begin
                        if (i_item.id_bit != i_item.complement_bit) begin
                            dir = i_item.id_bit;
                        end else begin
                            // Both branches exist: follow the stored path below the
                            // last discrepancy, take 1 at it, take 0 beyond it.
                            if (r_pos < r_ld) begin
                                dir = r_rom[idx];
                            end else begin
                                dir = (r_pos == r_ld);
                            end
                            if (!dir) begin
                                n_lzp = r_pos;
                                if (r_pos < ors_pkg::FAMILY_LIMIT) begin
                                    n_fam = r_pos[3:0];
                                end
                            end
                        end
                        n_rom[idx] = dir;
                        fam_bit    = n_fam;
                        n_pos      = r_pos + 7'd1;
                        kind0      = ors_pkg::KIND_DIR;
                        if (n_pos >= ors_pkg::FINAL_POSITION) begin
                            done     = 1'b1;
                            cnt      = 2'd2;
                            n_active = 1'b0;
                            n_ld     = n_lzp;
                            if (n_lzp == '0) begin
                                n_ldev = 1'b1;
                            end
                            if (n_rom[7:0] == 8'd0) begin
                                n_ld   = '0;
                                n_fam  = '0;
                                n_ldev = 1'b0;
                                kind1  = ors_pkg::KIND_NONE;
                            end else begin
                                kind1  = ors_pkg::KIND_FOUND;
                            end
                        end
                    end
                end
            end
            default: begin
                cnt = 2'd0;
            end
        endcase
    end

    always_comb begin
        o_res.cnt                     = cnt;
        o_res.res0.kind               = kind0;
        o_res.res0.direction          = dir;
        o_res.res0.rom_code           = n_rom;
        // On completion the first result still shows the flag and family
        // value from before the pass was closed.
        o_res.res0.last_device        = done ? r_ldev : n_ldev;
        o_res.res0.family_discrepancy = done ? fam_bit : n_fam;
        o_res.res0.last               = !done;
        o_res.res1.kind               = kind1;
        o_res.res1.direction          = 1'b0;
        o_res.res1.rom_code           = n_rom;
        o_res.res1.last_device        = n_ldev;
        o_res.res1.family_discrepancy = n_fam;
        o_res.res1.last               = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rom    <= '0;
            r_ld     <= '0;
            r_fam    <= '0;
            r_ldev   <= 1'b0;
            r_pos    <= 7'd1;
            r_lzp    <= '0;
            r_active <= 1'b0;
        end else if (i_fire) begin
            r_rom    <= n_rom;
            r_ld     <= n_ld;
            r_fam    <= n_fam;
            r_ldev   <= n_ldev;
            r_pos    <= n_pos;
            r_lzp    <= n_lzp;
            r_active <= n_active;
        end
    end

`ifndef NO_ASSERTIONS
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos != 7'd0 && r_pos <= ors_pkg::FINAL_POSITION)
        else $error("bit position out of range");
    a_done_ends_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && done |=> !r_active)
        else $error("pass still active after the last bit");
    a_fam_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fam < 4'd9)
        else $error("family discrepancy beyond the family byte");
`endif

endmodule

### rtl/ors_out.sv
module ors_out (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_wr,
    input  ors_pkg::t_core_res i_res,
    output logic               o_space,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output ors_pkg::t_out      o_out_data
);

    ors_pkg::t_out r_buf [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_count;
    logic          pop;

    assign o_out_valid = (r_count != 2'd0);
    assign pop         = o_out_valid && !i_out_stall;
    assign o_out_data  = r_buf[r_rp];
    // Room for the largest item (two results), counting the transfer in this cycle.
    assign o_space     = (r_count == 2'd0) || (r_count == 2'd1 && pop);

    always_ff @(posedge i_clk) begin
        if (i_wr && i_res.cnt != 2'd0) begin
            r_buf[r_wp] <= i_res.res0;
        end
        if (i_wr && i_res.cnt == 2'd2) begin
            r_buf[~r_wp] <= i_res.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= '0;
        end else begin
            if (i_wr) begin
                r_wp <= r_wp ^ i_res.cnt[0];
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_count <= r_count + (i_wr ? i_res.cnt : 2'd0) - {1'b0, pop};
        end
    end

`ifndef NO_ASSERTIONS
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'd2)
        else $error("result buffer overflow");
    a_wr_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr && i_res.cnt == 2'd2 |-> o_space)
        else $error("two results written without room");
    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_wr && pop |=> r_count == $past(r_count) - 2'd1)
        else $error("result count lost track of a transfer");
`endif

endmodule

### rtl/onewire_rom_search_engine.sv
// Results: a result is offered once its item has moved from the input register into
// the result buffer; the second result of a completing bit pair is offered once the
// first has been taken.
// Throughput: one item per cycle while the output side takes results; a completing bit
// pair with two results holds the next item back while both results are in the buffer.
// Reset (i_rst_n low, synchronous) empties both registers, clears the ROM and the
// discrepancy state, and sets the bit position to 1.
module onewire_rom_search_engine (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  ors_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output ors_pkg::t_out o_out_data
);

    logic               r_in_vld;
    ors_pkg::t_in       r_in;
    logic               space;
    logic               fire;
    ors_pkg::t_core_res res;

    assign fire       = r_in_vld && space;
    assign o_in_stall = r_in_vld && !fire;

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_in_vld <= 1'b1;
        end else if (fire) begin
            r_in_vld <= 1'b0;
        end
    end

    ors_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_item  (r_in),
        .o_res   (res)
    );

    ors_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr        (fire),
        .i_res       (res),
        .o_space     (space),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

`ifndef NO_ASSERTIONS
    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && !fire |=> r_in_vld)
        else $error("pending item dropped");
    a_in_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> r_in_vld)
        else $error("accepted item not registered");
    a_fire_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && res.cnt != 2'd0 |=> o_out_valid)
        else $error("result not offered after processing");
`endif

endmodule

### sim/onewire_rom_search_checker.sv
module onewire_rom_search_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_stall,
    input  ors_pkg::t_in  i_in_data,
    input  logic          i_out_valid,
    input  logic          i_out_stall,
    input  ors_pkg::t_out i_out_data,
    output int            o_errors,
    output int            o_pending,
    output int            o_checked,
    output int            o_found
);
    timeunit 1ns;
    timeprecision 1ps;

    // Search state as the block should hold it.
    logic [63:0] rom_bits;
    logic [6:0]  disc_pos;
    logic [3:0]  family_disc;
    logic        found_last;
    logic [6:0]  bit_pos;
    logic [6:0]  zero_pos;
    logic        searching;

    ors_pkg::t_out exp_q[$];

    function automatic ors_pkg::t_out make_expected(logic [1:0] kind, logic dir, logic fin);
        ors_pkg::t_out r;
        r.kind               = kind;
        r.direction          = dir;
        r.rom_code           = rom_bits;
        r.last_device        = found_last;
        r.family_discrepancy = family_disc;
        r.last               = fin;
        return r;
    endfunction

    task automatic forget_discrepancies();
        disc_pos    = '0;
        family_disc = '0;
        found_last  = 1'b0;
    endtask

    task automatic predict_search(input ors_pkg::t_in item);
        logic [6:0] pos;
        logic [5:0] idx;
        logic       dir;
        case (item.operation)
            ors_pkg::OP_BEGIN: begin
                if (found_last || !item.presence) begin
                    forget_discrepancies();
                    searching = 1'b0;
                    exp_q.push_back(make_expected(ors_pkg::KIND_NONE, 1'b0, 1'b1));
                end else begin
                    searching = 1'b1;
                    bit_pos   = 7'd1;
                    zero_pos  = '0;
                    exp_q.push_back(make_expected(ors_pkg::KIND_STARTED, 1'b0, 1'b1));
                end
            end
            ors_pkg::OP_CLEAR: begin
                forget_discrepancies();
                searching = 1'b0;
            end
            ors_pkg::OP_ABORT: begin
                searching = 1'b0;
                exp_q.push_back(make_expected(ors_pkg::KIND_NONE, 1'b0, 1'b1));
            end
            ors_pkg::OP_BIT: begin
                if (searching && item.id_bit && item.complement_bit) begin
                    searching = 1'b0;
                    forget_discrepancies();
                    exp_q.push_back(make_expected(ors_pkg::KIND_NONE, 1'b0, 1'b1));
                end else if (searching) begin
                    pos = bit_pos;
                    idx = pos[5:0] - 6'd1;
                    if (item.id_bit != item.complement_bit) begin
                        dir = item.id_bit;
                    end else begin
                        // Devices disagree: follow the stored path below the last
                        // discrepancy, take the one branch at it, the zero branch past it.
                        if (pos < disc_pos) begin
                            dir = rom_bits[idx];
                        end else begin
                            dir = (pos == disc_pos);
                        end
                        if (!dir) begin
                            zero_pos = pos;
                            if (pos < ors_pkg::FAMILY_LIMIT) begin
                                family_disc = pos[3:0];
                            end
                        end
                    end
                    rom_bits[idx] = dir;
                    bit_pos = pos + 7'd1;
                    if (bit_pos < ors_pkg::FINAL_POSITION) begin
                        exp_q.push_back(make_expected(ors_pkg::KIND_DIR, dir, 1'b1));
                    end else begin
                        exp_q.push_back(make_expected(ors_pkg::KIND_DIR, dir, 1'b0));
                        searching = 1'b0;
                        disc_pos  = zero_pos;
                        if (disc_pos == '0) begin
                            found_last = 1'b1;
                        end
                        // A zero family byte means the walk read no real device.
                        if (rom_bits[7:0] == 8'h00) begin
                            forget_discrepancies();
                            exp_q.push_back(make_expected(ors_pkg::KIND_NONE, 1'b0, 1'b1));
                        end else begin
                            exp_q.push_back(make_expected(ors_pkg::KIND_FOUND, 1'b0, 1'b1));
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    endtask

    task automatic compare_result(input ors_pkg::t_out got);
        ors_pkg::t_out want;
        logic          bad;
        if (exp_q.size() == 0) begin
            o_errors++;
            if (o_errors <= 10) begin
                $display("%0t: result transfer with nothing expected: kind %0d rom %h",
                         $time, got.kind, got.rom_code);
            end
        end else begin
            want = exp_q.pop_front();
            o_checked++;
            if (got.kind == ors_pkg::KIND_FOUND) begin
                o_found++;
            end
            bad = (got.kind !== want.kind) || (got.direction !== want.direction) ||
                  (got.rom_code !== want.rom_code) ||
                  (got.last_device !== want.last_device) ||
                  (got.family_discrepancy !== want.family_discrepancy) ||
                  (got.last !== want.last);
            if (bad) begin
                o_errors++;
                if (o_errors <= 10) begin
                    $display("%0t: mismatch (expected/actual) kind %0d/%0d dir %0d/%0d",
                             $time, want.kind, got.kind, want.direction, got.direction);
                    $display("    rom %h/%h last_device %0d/%0d family %0d/%0d last %0d/%0d",
                             want.rom_code, got.rom_code, want.last_device,
                             got.last_device, want.family_discrepancy,
                             got.family_discrepancy, want.last, got.last);
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rom_bits  = '0;
            bit_pos   = 7'd1;
            zero_pos  = '0;
            searching = 1'b0;
            forget_discrepancies();
            exp_q.delete();
            o_errors  = 0;
            o_checked = 0;
            o_found   = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                compare_result(i_out_data);
            end
            if (i_in_valid && !i_in_stall) begin
                predict_search(i_in_data);
            end
        end
        o_pending = exp_q.size();
    end

endmodule

### sim/onewire_rom_search_engine_tb.sv
module onewire_rom_search_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic          clk       = 1'b0;
    logic          rst_n     = 1'b0;
    logic          in_valid  = 1'b0;
    ors_pkg::t_in  in_data   = '0;
    logic          in_stall;
    logic          out_valid;
    logic          out_stall = 1'b0;
    ors_pkg::t_out out_data;

    int errors;
    int pending;
    int checked;
    int found;

    // Bit pairs of the last pass, as {id_bit, complement_bit}; replayed only after a complete pass.
    logic [1:0] prev_pairs [64];
    logic       have_prev   = 1'b0;
    logic       no_idle     = 1'b0;
    int         items_sent  = 0;
    int         full_passes = 0;
    int         pass_count  = 0;
    int         hold_cycles = 0;

    always #10 clk = ~clk;

    onewire_rom_search_engine u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    onewire_rom_search_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_data  (out_data),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_checked   (checked),
        .o_found     (found)
    );

    // After each result transfer the receiver holds off for a random number of cycles, or for none in no-idle passes.
    always @(posedge clk) begin
        if (out_valid && !out_stall) begin
            hold_cycles = no_idle ? 0 : $urandom_range(0, 15);
        end
        if (hold_cycles > 0) begin
            out_stall <= 1'b1;
            hold_cycles--;
        end else begin
            out_stall <= 1'b0;
        end
    end

    task automatic send_item(input logic [1:0] op, input logic presence,
                             input logic id_b, input logic cmp_b);
        ors_pkg::t_in item;
        int           gap;
        item.operation      = op;
        item.presence       = presence;
        item.id_bit         = id_b;
        item.complement_bit = cmp_b;
        gap = no_idle ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (in_stall);
        items_sent++;
    endtask

    function automatic logic [1:0] fresh_pair(int zero_odds);
        if ($urandom_range(0, 299) == 0) begin
            return 2'b11;
        end
        if (zero_odds > 0 && $urandom_range(1, zero_odds) == 1) begin
            return 2'b00;
        end
        return $urandom_range(0, 1) ? 2'b10 : 2'b01;
    endfunction

    // One search pass: a begin, up to 64 bit pairs and sometimes an abort or clear. Replaying the previous
    // pass makes the block walk further down the same tree.
    task automatic run_pass();
        int         style;
        int         cut;
        logic [1:0] pair;
        logic       broken;
        case (pass_count)
            0:       style = 6;
            1:       style = 0;
            2:       style = 5;
            3:       style = 4;
            default: style = $urandom_range(0, 9);
        endcase
        pass_count++;
        no_idle = ($urandom_range(0, 3) == 0);
        cut = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 63) : 64;
        broken = 1'b0;
        send_item(ors_pkg::OP_BEGIN, 1'b1, 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
        for (int b = 0; b < cut; b++) begin
            if (style < 4 && have_prev) begin
                pair = prev_pairs[6'(b)];
                if ($urandom_range(0, 31) == 0) begin
                    pair = fresh_pair(4);
                end
            end else if (style == 4) begin
                pair = fresh_pair(0);
            end else if (style == 5) begin
                pair = (b < 8) ? 2'b01 : fresh_pair(8);
            end else if (style == 6) begin
                pair = fresh_pair(2);
            end else begin
                pair = fresh_pair(16);
            end
            prev_pairs[6'(b)] = pair;
            send_item(ors_pkg::OP_BIT, 1'($urandom_range(0, 1)), pair[1], pair[0]);
            if (pair == 2'b11) begin
                broken = 1'b1;
                break;
            end
        end
        have_prev = (cut == 64) && !broken;
        if (have_prev) begin
            full_passes++;
        end else if (!broken && $urandom_range(0, 1)) begin
            send_item($urandom_range(0, 1) ? ors_pkg::OP_ABORT : ors_pkg::OP_CLEAR,
                      1'b0, 1'b0, 1'b0);
        end
    endtask

    initial begin
        int wait_count;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part: every operation, the ignored and restart cases, both-ones,
        // abort, clear, and a begin without presence.
        send_item(ors_pkg::OP_BIT,   1'b1, 1'b1, 1'b1);
        send_item(ors_pkg::OP_ABORT, 1'b0, 1'b0, 1'b0);
        send_item(ors_pkg::OP_BEGIN, 1'b0, 1'b1, 1'b1);
        send_item(ors_pkg::OP_BEGIN, 1'b1, 1'b0, 1'b0);
        send_item(ors_pkg::OP_BIT,   1'b0, 1'b0, 1'b1);
        send_item(ors_pkg::OP_BIT,   1'b1, 1'b1, 1'b0);
        send_item(ors_pkg::OP_BIT,   1'b0, 1'b0, 1'b0);
        send_item(ors_pkg::OP_BEGIN, 1'b1, 1'b1, 1'b0);
        send_item(ors_pkg::OP_BIT,   1'b0, 1'b1, 1'b0);
        send_item(ors_pkg::OP_BIT,   1'b0, 1'b1, 1'b1);
        send_item(ors_pkg::OP_BIT,   1'b1, 1'b0, 1'b0);
        send_item(ors_pkg::OP_BEGIN, 1'b1, 1'b0, 1'b1);
        send_item(ors_pkg::OP_ABORT, 1'b1, 1'b1, 1'b1);
        send_item(ors_pkg::OP_CLEAR, 1'b1, 1'b1, 1'b1);
        send_item(ors_pkg::OP_BEGIN, 1'b1, 1'b0, 1'b0);
        send_item(ors_pkg::OP_BIT,   1'b0, 1'b0, 1'b0);
        send_item(ors_pkg::OP_CLEAR, 1'b0, 1'b0, 1'b0);
        send_item(ors_pkg::OP_BIT,   1'b0, 1'b1, 1'b0);
        send_item(ors_pkg::OP_BEGIN, 1'b0, 1'b0, 1'b0);

        while (items_sent < 1200) begin
            run_pass();
            if ($urandom_range(0, 2) == 0) begin
                repeat ($urandom_range(1, 3)) begin
                    send_item(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                end
            end
        end
        in_valid <= 1'b0;

        wait_count = 0;
        while (pending != 0 && wait_count < 5000) begin
            @(posedge clk);
            wait_count++;
        end
        repeat (20) @(posedge clk);

        if (pending != 0) begin
            $display("%0d expected results never arrived", pending);
        end
        $display("Sent %0d items in %0d search passes, %0d of them run to the 64th bit.",
                 items_sent, pass_count, full_passes);
        $display("Checked %0d results, %0d devices found, %0d mismatches.",
                 checked, found, errors);
        if (errors == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #15_000_000;
        $display("Run did not finish in time.");
        $display("FAILURE");
        $finish;
    end

endmodule
